// File: sv/blsr_pkg.sv
// Shared types and constants for the bounded list with search and remove.
// No dependencies; every other file of the block refers to this package.
package blsr_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_OUT_W  = 7;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_FIND       = 3'd5,
    CMD_CLEAR      = 3'd6
  } command_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic                     found;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } result_t;

endpackage

// File: sv/blsr_if.sv
// Handshake interfaces for the command and response channels.
// Depends on blsr_pkg for the payload widths.
interface blsr_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          command;
  logic signed [blsr_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface blsr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic                             found;
  logic [blsr_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output found, output entry_count, input ready);
  modport sink (input valid, input status, input found, input entry_count, output ready);
endinterface

// File: sv/blsr_store.sv
// Entry store: one write port and one read port with registered read data.
// Depends on blsr_pkg for the value width.
module blsr_store #(
  parameter int CAPACITY = blsr_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [IW-1:0]               waddr,
  input  logic [blsr_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [IW-1:0]               raddr,
  output logic [blsr_pkg::VALUE_W-1:0] rdata
);

  logic [blsr_pkg::VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/blsr_ctrl.sv
// Command sequencer: decodes items, keeps front and count, scans and shifts the store.
// Depends on blsr_pkg and blsr_if; drives the ports of blsr_store.
module blsr_ctrl #(
  parameter int CAPACITY = blsr_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  blsr_cmd_if.sink                     cmd,
  input  logic                         rsp_free,
  output logic                         done,
  output blsr_pkg::result_t            result,
  output logic                         mem_we,
  output logic [IW-1:0]                mem_waddr,
  output logic [blsr_pkg::VALUE_W-1:0] mem_wdata,
  output logic                         mem_re,
  output logic [IW-1:0]                mem_raddr,
  input  logic [blsr_pkg::VALUE_W-1:0] mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_SLOT  = IW'(CAPACITY - 1);

  state_t                       state, state_next;
  logic [IW-1:0]                front, front_next;
  logic [CW-1:0]                count, count_next;
  logic [blsr_pkg::VALUE_W-1:0] val, val_next;
  logic                         is_remove, is_remove_next;
  logic [IW-1:0]                rd_slot, rd_slot_next;
  logic [IW-1:0]                cmp_slot, cmp_slot_next;
  logic [CW-1:0]                cmp_pos, cmp_pos_next;
  logic [IW-1:0]                wr_slot, wr_slot_next;
  blsr_pkg::status_t            status, status_next;
  logic                         found, found_next;
  logic [CW-1:0]                cmp_pos_inc;
  logic                         last;
  logic                         accept;

  function automatic logic [IW-1:0] inc_slot(input logic [IW-1:0] s);
    return (s == LAST_SLOT) ? '0 : IW'(s + 1'b1);
  endfunction

  function automatic logic [IW-1:0] dec_slot(input logic [IW-1:0] s);
    return (s == '0) ? LAST_SLOT : IW'(s - 1'b1);
  endfunction

  // Slot of logical position pos, where pos is below CAPACITY.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] f, input logic [CW-1:0] pos);
    logic [IW:0] sum;
    sum = {1'b0, f} + (IW + 1)'(pos);
    if (sum >= (IW + 1)'(CAPACITY)) begin
      sum = sum - (IW + 1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign cmd.ready   = (state == S_IDLE) && !rst;
  assign accept      = cmd.valid && cmd.ready;
  assign cmp_pos_inc = CW'(cmp_pos + 1'b1);
  assign last        = (cmp_pos_inc == count);

  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    val_next       = val;
    is_remove_next = is_remove;
    rd_slot_next   = rd_slot;
    cmp_slot_next  = cmp_slot;
    cmp_pos_next   = cmp_pos;
    wr_slot_next   = wr_slot;
    status_next    = status;
    found_next     = found;
    mem_we         = 1'b0;
    mem_waddr      = wr_slot;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = rd_slot;
    done           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          val_next       = cmd.value;
          status_next    = blsr_pkg::ST_OK;
          found_next     = 1'b0;
          is_remove_next = (cmd.command == blsr_pkg::CMD_REMOVE);
          state_next     = S_DONE;
          unique case (cmd.command) inside
            blsr_pkg::CMD_PUSH_FRONT: begin
              if (count == FULL_COUNT) begin
                status_next = blsr_pkg::ST_FULL;
              end else begin
                front_next = dec_slot(front);
                mem_we     = 1'b1;
                mem_waddr  = dec_slot(front);
                mem_wdata  = cmd.value;
                count_next = CW'(count + 1'b1);
              end
            end
            blsr_pkg::CMD_PUSH_BACK: begin
              if (count == FULL_COUNT) begin
                status_next = blsr_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = slot_of(front, count);
                mem_wdata  = cmd.value;
                count_next = CW'(count + 1'b1);
              end
            end
            blsr_pkg::CMD_POP_FRONT: begin
              if (count == '0) begin
                status_next = blsr_pkg::ST_EMPTY;
              end else begin
                front_next = inc_slot(front);
                count_next = CW'(count - 1'b1);
              end
            end
            blsr_pkg::CMD_POP_BACK: begin
              if (count == '0) begin
                status_next = blsr_pkg::ST_EMPTY;
              end else begin
                count_next = CW'(count - 1'b1);
              end
            end
            blsr_pkg::CMD_REMOVE, blsr_pkg::CMD_FIND: begin
              if (count == '0) begin
                status_next = blsr_pkg::ST_EMPTY;
              end else begin
                // Read the front entry; it is compared in the next cycle.
                mem_re        = 1'b1;
                mem_raddr     = front;
                cmp_pos_next  = '0;
                cmp_slot_next = front;
                rd_slot_next  = inc_slot(front);
                state_next    = S_SCAN;
              end
            end
            blsr_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // The read one position ahead is always issued; it feeds the shift on a match.
        mem_re        = 1'b1;
        rd_slot_next  = inc_slot(rd_slot);
        cmp_slot_next = rd_slot;
        cmp_pos_next  = cmp_pos_inc;
        if (mem_rdata == val) begin
          found_next = 1'b1;
          if (!is_remove) begin
            state_next = S_DONE;
          end else if (last) begin
            count_next = CW'(count - 1'b1);
            state_next = S_DONE;
          end else begin
            wr_slot_next = cmp_slot;
            state_next   = S_SHIFT;
          end
        end else if (last) begin
          status_next = blsr_pkg::ST_NOTFOUND;
          state_next  = S_DONE;
        end
      end
      S_SHIFT: begin
        // Each entry after the match moves one slot toward the front.
        mem_re        = 1'b1;
        rd_slot_next  = inc_slot(rd_slot);
        cmp_slot_next = rd_slot;
        cmp_pos_next  = cmp_pos_inc;
        mem_we        = 1'b1;
        wr_slot_next  = cmp_slot;
        if (last) begin
          count_next = CW'(count - 1'b1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
    val       <= val_next;
    is_remove <= is_remove_next;
    rd_slot   <= rd_slot_next;
    cmp_slot  <= cmp_slot_next;
    cmp_pos   <= cmp_pos_next;
    wr_slot   <= wr_slot_next;
    status    <= status_next;
    found     <= found_next;
  end

  assign result = '{status: status, found: found,
                    entry_count: blsr_pkg::COUNT_OUT_W'(count)};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_no_same_slot: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same slot in one cycle");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && count == FULL_COUNT &&
     (cmd.command == blsr_pkg::CMD_PUSH_FRONT || cmd.command == blsr_pkg::CMD_PUSH_BACK))
    |=> ($stable(count) && $stable(front)))
    else $error("push into a full list changed the list");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (cmp_pos < count && count != '0))
    else $error("shift runs past the last entry");

endmodule

// File: sv/bounded_list_with_search_remove_unit.sv
// Top level of the bounded list with search and remove: sequencer, store, result register.
// Depends on blsr_pkg, blsr_if, blsr_ctrl and blsr_store.
//
//   Channel  Direction  Payload                              Handshake
//   cmd      in         command[2:0], value[31:0] signed     valid/ready
//   rsp      out        status[1:0], found, entry_count[6:0] valid/ready
//
// Push, pop, clear and unused codes go from IDLE straight to DONE: the result is loaded
// from DONE once the output register is free, and the next item is taken back in IDLE.
// Find and remove read the store one entry per cycle through its single read port,
// scanning in SCAN and, when a remove matches before the last entry, shifting in SHIFT.
// Reset (rst, synchronous) empties the list; the store itself is not cleared.
// A result waits in its output register while the next item is taken; a stalled rsp
// channel holds the sequencer only when the following result is ready to be loaded.
module bounded_list_with_search_remove_unit #(
  parameter int CAPACITY = blsr_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY)
) (
  input logic        clk,
  input logic        rst,
  blsr_cmd_if.sink   cmd,
  blsr_rsp_if.source rsp
);

  logic                         done;
  blsr_pkg::result_t            result;
  logic                         rsp_free;
  logic                         mem_we;
  logic [IW-1:0]                mem_waddr;
  logic [blsr_pkg::VALUE_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [IW-1:0]                mem_raddr;
  logic [blsr_pkg::VALUE_W-1:0] mem_rdata;

  logic              rsp_valid;
  blsr_pkg::result_t rsp_data;

  // The output register is free when empty or when its item leaves this cycle.
  assign rsp_free = !rsp_valid || rsp.ready;

  blsr_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rsp_free  (rsp_free),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  blsr_store #(.CAPACITY(CAPACITY)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (done) begin
      rsp_data <= result;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_data.status;
  assign rsp.found       = rsp_data.found;
  assign rsp.entry_count = rsp_data.entry_count;

endmodule
